/* rtl/coin_payment_change_maker_macros.svh */
// assertion macros for the coin payment and change maker
// used by the top level only, expects clk and arst_n in scope
`ifndef COIN_PAYMENT_CHANGE_MAKER_MACROS_SVH
`define COIN_PAYMENT_CHANGE_MAKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPCM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CPCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cpcm_pkg.sv */
// shared types, codes and coin tables for the coin payment and change maker
// no dependencies
`timescale 1ns / 1ps

package cpcm_pkg;

	localparam int DENOMS = 8;
	localparam int IDX_W = $clog2(DENOMS);
	localparam int CNT_W = 8;
	localparam int AMT_W = 16;
	localparam int VAL_W = 10;
	localparam int RECIP_W = 18;
	localparam int RECIP_SHIFT = 20;
	localparam int ACC_W = 19;
	localparam logic [CNT_W-1:0] DEFAULT_STOCK = 8'd20;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_CANCEL  = 2'd1,
		ACT_RESTOCK = 2'd2,
		ACT_IGNORE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_DUE     = 3'd0,
		KIND_CHANGE  = 3'd1,
		KIND_DONE    = 3'd2,
		KIND_REFUND  = 3'd3,
		KIND_RESTOCK = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		OP_FETCH,
		OP_INSERT,
		OP_NOP,
		OP_QUOT,
		OP_TAKE,
		OP_DONE,
		OP_DUE,
		OP_CANCEL,
		OP_REFUND,
		OP_RESTOCK
	} op_t;

	typedef struct packed {
		op_t  op;
		logic accept;
	} ctrl_t;

	typedef struct packed {
		logic gt;
		logic idx_nz;
		logic hold;
	} status_t;

	function automatic logic [VAL_W-1:0] coin_value(input logic [IDX_W-1:0] idx);
		logic [VAL_W-1:0] v;
		case (idx)
			3'd0:    v = 10'd5;
			3'd1:    v = 10'd10;
			3'd2:    v = 10'd20;
			3'd3:    v = 10'd50;
			3'd4:    v = 10'd100;
			3'd5:    v = 10'd200;
			3'd6:    v = 10'd500;
			default: v = 10'd1000;
		endcase
		return v;
	endfunction

	// ceil(2^20 / value), exact quotient for change up to 1000
	function automatic logic [RECIP_W-1:0] coin_recip(input logic [IDX_W-1:0] idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			3'd0:    r = 18'd209716;
			3'd1:    r = 18'd104858;
			3'd2:    r = 18'd52429;
			3'd3:    r = 18'd20972;
			3'd4:    r = 18'd10486;
			3'd5:    r = 18'd5243;
			3'd6:    r = 18'd2098;
			default: r = 18'd1049;
		endcase
		return r;
	endfunction

endpackage

/* rtl/coin_payment_change_maker.sv */
// Coin payment and change maker. Requests come in on the cmd channel
// (action, coin_code), results leave on the rsp channel, one per cycle at most.
// A request is taken at a rising edge with cmd_valid high and cmd_stall low;
// a result is taken at an edge with rsp_valid high and rsp_stall low.
// The price register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
// A microcoded sequencer steps through a short program per request, so
// only one request is in flight; cmd_stall is low only in the fetch step.
// A restock runs the restock step; a coin still owed runs the insert step,
// a branch step and the due step; cancel runs one step per denomination,
// then the refund step. A paying coin runs two steps per denomination
// (quotient, then take), then the done step, change items in between.
// The next request is taken the cycle after the last result is loaded into the output register.
// When the receiver stalls, the output register holds its result and the
// sequencer waits on the next step that has a result to give.
// Reset puts every stock count at 20, clears the tally, the amount due
// and the price.
`timescale 1ns / 1ps
`include "coin_payment_change_maker_macros.svh"

module coin_payment_change_maker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [1:0]                   action,
	input  logic [2:0]                   coin_code,
	input  logic                         cfg_we,
	input  logic [cpcm_pkg::AMT_W-1:0]   cfg_wdata,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [2:0]                   kind,
	output logic [cpcm_pkg::AMT_W-1:0]   amount,
	output logic [2:0]                   denomination,
	output logic [cpcm_pkg::CNT_W-1:0]   coin_count,
	output logic                         last
);
	import cpcm_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	cpcm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_action (action),
		.status     (status),
		.cmd_stall  (cmd_stall),
		.ctrl       (ctrl)
	);

	cpcm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd_coin_code (coin_code),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.rsp_valid     (rsp_valid),
		.rsp_kind      (kind),
		.rsp_amount    (amount),
		.rsp_denom     (denomination),
		.rsp_count     (coin_count),
		.rsp_last      (last)
	);

	`CPCM_ASSERT_NOW(a_change_nonzero, rsp_valid && (kind == KIND_CHANGE), coin_count != '0, "change item with zero coins")
	`CPCM_ASSERT_NOW(a_only_change_mid, rsp_valid && !last, kind == KIND_CHANGE, "non-final result that is not change")
	`CPCM_ASSERT_NEXT(a_hold_keeps_step, status.hold, ctrl.op == $past(ctrl.op), "sequencer moved while result blocked")

endmodule

/* rtl/cpcm_datapath.sv */
// datapath: coin stock and tally, amount due, change arithmetic and result register
// depends on cpcm_pkg, driven by the control word from cpcm_seq
`timescale 1ns / 1ps

module cpcm_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpcm_pkg::ctrl_t              ctrl,
	input  logic [2:0]                   cmd_coin_code,
	input  logic                         cfg_we,
	input  logic [cpcm_pkg::AMT_W-1:0]   cfg_wdata,
	input  logic                         rsp_stall,
	output cpcm_pkg::status_t            status,
	output logic                         rsp_valid,
	output logic [2:0]                   rsp_kind,
	output logic [cpcm_pkg::AMT_W-1:0]   rsp_amount,
	output logic [2:0]                   rsp_denom,
	output logic [cpcm_pkg::CNT_W-1:0]   rsp_count,
	output logic                         rsp_last
);
	import cpcm_pkg::*;

	logic [CNT_W-1:0]   stock_q [DENOMS];
	logic [CNT_W-1:0]   tally_q [DENOMS];
	logic [AMT_W-1:0]   price_q;
	logic [AMT_W-1:0]   due_q;
	logic               in_tx_q;
	logic [IDX_W-1:0]   code_q;
	logic [IDX_W-1:0]   idx_q;
	logic               gt_q;
	logic [VAL_W-1:0]   rest_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   acc_q;

	logic               rsp_valid_q;
	kind_t              rsp_kind_q;
	logic [AMT_W-1:0]   rsp_amount_q;
	logic [IDX_W-1:0]   rsp_denom_q;
	logic [CNT_W-1:0]   rsp_count_q;
	logic               rsp_last_q;

	logic [VAL_W-1:0]   val_code;
	logic [VAL_W-1:0]   val_idx;
	logic [AMT_W-1:0]   due_cur;
	logic [AMT_W-1:0]   due_diff;
	logic [AMT_W-1:0]   rest_diff;
	logic [27:0]        quot_prod;
	logic [CNT_W-1:0]   quot;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [17:0]        take_prod;
	logic [17:0]        tally_prod;
	logic [AMT_W-1:0]   refund_amt;

	logic               emit;
	logic               out_load;
	logic               adv;
	kind_t              kind_d;
	logic [AMT_W-1:0]   amount_d;
	logic [IDX_W-1:0]   denom_d;
	logic [CNT_W-1:0]   count_d;
	logic               last_d;

	assign val_code   = coin_value(code_q);
	assign val_idx    = coin_value(idx_q);
	assign due_cur    = in_tx_q ? due_q : price_q;
	assign due_diff   = due_cur - AMT_W'(val_code);
	assign rest_diff  = AMT_W'(val_code) - due_cur;
	assign quot_prod  = 28'(rest_q) * 28'(coin_recip(idx_q));
	assign quot       = quot_prod[RECIP_SHIFT +: CNT_W];
	assign cnt_nxt    = (quot < stock_q[idx_q]) ? quot : stock_q[idx_q];
	assign take_prod  = 18'(cnt_q) * 18'(val_idx);
	assign tally_prod = 18'(tally_q[idx_q]) * 18'(val_idx);
	assign refund_amt = (acc_q > ACC_W'(16'hFFFF)) ? 16'hFFFF : acc_q[AMT_W-1:0];

	// result selection per step
	always_comb begin
		emit     = 1'b0;
		kind_d   = KIND_DUE;
		amount_d = '0;
		denom_d  = '0;
		count_d  = '0;
		last_d   = 1'b1;
		unique case (ctrl.op)
			OP_TAKE: begin
				emit    = (cnt_q != '0);
				kind_d  = KIND_CHANGE;
				denom_d = idx_q;
				count_d = cnt_q;
				last_d  = 1'b0;
			end
			OP_DONE: begin
				emit     = 1'b1;
				kind_d   = KIND_DONE;
				amount_d = AMT_W'(rest_q);
			end
			OP_DUE: begin
				emit     = 1'b1;
				kind_d   = KIND_DUE;
				amount_d = due_q;
			end
			OP_REFUND: begin
				emit     = 1'b1;
				kind_d   = KIND_REFUND;
				amount_d = refund_amt;
			end
			OP_RESTOCK: begin
				emit   = 1'b1;
				kind_d = KIND_RESTOCK;
			end
			default: emit = 1'b0;
		endcase
	end

	assign out_load = emit && (!rsp_valid_q || !rsp_stall);
	assign adv      = !(emit && !out_load);

	assign status.gt     = gt_q;
	assign status.idx_nz = (idx_q != '0);
	assign status.hold   = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_kind_q   <= kind_d;
			rsp_amount_q <= amount_d;
			rsp_denom_q  <= denom_d;
			rsp_count_q  <= count_d;
			rsp_last_q   <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_q <= '0;
		end else if (cfg_we) begin
			price_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DENOMS; i++) begin
				stock_q[i] <= DEFAULT_STOCK;
				tally_q[i] <= '0;
			end
			due_q   <= '0;
			in_tx_q <= 1'b0;
			code_q  <= '0;
			idx_q   <= '0;
			gt_q    <= 1'b0;
			rest_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else if (adv) begin
			if (ctrl.accept) begin
				code_q <= cmd_coin_code;
				idx_q  <= '1;
				acc_q  <= '0;
			end
			unique case (ctrl.op)
				OP_INSERT: begin
					in_tx_q <= 1'b1;
					if (stock_q[code_q] != '1) stock_q[code_q] <= stock_q[code_q] + 1'b1;
					if (tally_q[code_q] != '1) tally_q[code_q] <= tally_q[code_q] + 1'b1;
					if (due_cur > AMT_W'(val_code)) begin
						due_q <= due_diff;
						gt_q  <= 1'b1;
					end else begin
						rest_q <= rest_diff[VAL_W-1:0];
						gt_q   <= 1'b0;
					end
				end
				OP_QUOT: cnt_q <= cnt_nxt;
				OP_TAKE: begin
					rest_q         <= rest_q - take_prod[VAL_W-1:0];
					stock_q[idx_q] <= stock_q[idx_q] - cnt_q;
					idx_q          <= idx_q - 1'b1;
				end
				OP_DONE: begin
					for (int i = 0; i < DENOMS; i++) tally_q[i] <= '0;
					due_q   <= '0;
					in_tx_q <= 1'b0;
				end
				OP_CANCEL: begin
					stock_q[idx_q] <= (stock_q[idx_q] > tally_q[idx_q]) ?
						stock_q[idx_q] - tally_q[idx_q] : '0;
					tally_q[idx_q] <= '0;
					acc_q          <= acc_q + ACC_W'(tally_prod);
					idx_q          <= idx_q - 1'b1;
				end
				OP_REFUND: begin
					due_q   <= '0;
					in_tx_q <= 1'b0;
				end
				OP_RESTOCK: begin
					for (int i = 0; i < DENOMS; i++) stock_q[i] <= DEFAULT_STOCK;
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_kind   = rsp_kind_q;
	assign rsp_amount = rsp_amount_q;
	assign rsp_denom  = rsp_denom_q;
	assign rsp_count  = rsp_count_q;
	assign rsp_last   = rsp_last_q;

endmodule

/* rtl/cpcm_seq.sv */
// microcode sequencer: step counter, control store and conditional jumps
// depends on cpcm_pkg, reads status from cpcm_datapath
`timescale 1ns / 1ps

module cpcm_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [1:0]          cmd_action,
	input  cpcm_pkg::status_t   status,
	output logic                cmd_stall,
	output cpcm_pkg::ctrl_t     ctrl
);
	import cpcm_pkg::*;

	typedef logic [3:0] pc_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_GT,
		C_IDX_NZ,
		C_DISPATCH
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	localparam pc_t PC_FETCH   = 4'd0;
	localparam pc_t PC_INSERT  = 4'd1;
	localparam pc_t PC_QUOT    = 4'd3;
	localparam pc_t PC_DUE     = 4'd6;
	localparam pc_t PC_CANCEL  = 4'd7;
	localparam pc_t PC_RESTOCK = 4'd9;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			4'd0:    w = '{OP_FETCH,   C_DISPATCH, PC_FETCH};
			4'd1:    w = '{OP_INSERT,  C_NEXT,     PC_FETCH};
			4'd2:    w = '{OP_NOP,     C_GT,       PC_DUE};
			4'd3:    w = '{OP_QUOT,    C_NEXT,     PC_FETCH};
			4'd4:    w = '{OP_TAKE,    C_IDX_NZ,   PC_QUOT};
			4'd5:    w = '{OP_DONE,    C_JUMP,     PC_FETCH};
			4'd6:    w = '{OP_DUE,     C_JUMP,     PC_FETCH};
			4'd7:    w = '{OP_CANCEL,  C_IDX_NZ,   PC_CANCEL};
			4'd8:    w = '{OP_REFUND,  C_JUMP,     PC_FETCH};
			4'd9:    w = '{OP_RESTOCK, C_JUMP,     PC_FETCH};
			default: w = '{OP_NOP,     C_JUMP,     PC_FETCH};
		endcase
		return w;
	endfunction

	pc_t    pc_q;
	pc_t    pc_d;
	pc_t    pc_inc;
	ucode_t uw;

	assign uw     = ucode_rom(pc_q);
	assign pc_inc = pc_q + 1'b1;

	always_comb begin
		pc_d = pc_q;
		if (!status.hold) begin
			unique case (uw.cond)
				C_NEXT:   pc_d = pc_inc;
				C_JUMP:   pc_d = uw.target;
				C_GT:     pc_d = status.gt ? uw.target : pc_inc;
				C_IDX_NZ: pc_d = status.idx_nz ? uw.target : pc_inc;
				C_DISPATCH: begin
					if (cmd_valid) begin
						unique case (action_t'(cmd_action))
							ACT_INSERT:  pc_d = PC_INSERT;
							ACT_CANCEL:  pc_d = PC_CANCEL;
							ACT_RESTOCK: pc_d = PC_RESTOCK;
							default:     pc_d = PC_FETCH;
						endcase
					end
				end
				default:  pc_d = PC_FETCH;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign cmd_stall   = (uw.op != OP_FETCH);
	assign ctrl.op     = uw.op;
	assign ctrl.accept = (uw.op == OP_FETCH) && cmd_valid;

endmodule
